/* design/udd_pkg.sv */
// Package for the UART drain delay calculator: constants, queue entry and
// status types, register index codes, back-end state type and frame sizing.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package udd_pkg;

  localparam int BAUD_W      = 24;
  localparam int COUNT_W     = 9;
  localparam int DELAY_W     = 17;
  localparam int FBITS_W     = 4;
  localparam int CNTFB_W     = 12;  // saturated count times frame bits, up to 3072
  localparam int NUM_W       = 32;  // numerator, up to 3.072e9
  localparam int STEP_W      = $clog2(NUM_W);
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int CFG_IDX_W   = 2;

  localparam logic [BAUD_W-1:0]  DEFAULT_BAUD = 24'd115200;
  localparam logic [19:0]        USEC_PER_SEC = 20'd1000000;
  localparam logic [DELAY_W-1:0] MIN_DELAY_US = 17'd1000;
  localparam logic [DELAY_W-1:0] MAX_DELAY_US = 17'd100000;
  localparam logic [COUNT_W-1:0] MAX_CHUNK    = 9'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_RATE   = 2'd0,
    CFG_DATA_BITS   = 2'd1,
    CFG_PARITY_EN   = 2'd2,
    CFG_TWO_STOP    = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_FIN
  } back_state_t;

  typedef struct packed {
    logic               zero;
    logic [CNTFB_W-1:0] cnt_fb;
    logic [FBITS_W-1:0] fbits;
    logic [BAUD_W-1:0]  baud;
  } udd_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } udd_q_stat_t;

  // Start + data + optional parity + one or two stop bits.
  function automatic logic [FBITS_W-1:0] frame_size(input logic [1:0] data_code,
                                                    input logic       parity,
                                                    input logic       two_stop);
    logic [FBITS_W-1:0] n;
    n = FBITS_W'(6) + FBITS_W'(data_code) + FBITS_W'(parity)
        + (two_stop ? FBITS_W'(2) : FBITS_W'(1));
    return n;
  endfunction

endpackage

`default_nettype wire

/* design/udd_front.sv */
// Front end of the drain delay calculator: classifies an incoming byte count
// and builds a queue entry. Depends on udd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module udd_front import udd_pkg::*; (
  input  wire logic               in_valid,
  input  wire logic [COUNT_W-1:0] in_byte_count,
  input  wire logic [BAUD_W-1:0]  line_rate,
  input  wire logic [1:0]         data_bits_code,
  input  wire logic               parity_enable,
  input  wire logic               two_stop_bits,
  input  wire udd_q_stat_t        q_stat,
  output logic                    in_stall,
  output logic                    push,
  output udd_entry_t              entry
);

  logic [COUNT_W-1:0] count_sat;
  logic [FBITS_W-1:0] fbits;

  always_comb begin
    count_sat = (in_byte_count > MAX_CHUNK) ? MAX_CHUNK : in_byte_count;
    fbits     = frame_size(data_bits_code, parity_enable, two_stop_bits);

    entry.zero   = (in_byte_count == '0);
    entry.cnt_fb = CNTFB_W'(CNTFB_W'(count_sat) * CNTFB_W'(fbits));
    entry.fbits  = fbits;
    // zero baud falls back to the default line rate
    entry.baud   = (line_rate == '0) ? DEFAULT_BAUD : line_rate;

    in_stall = q_stat.full;
    push     = in_valid && !q_stat.full;
  end

endmodule

`default_nettype wire

/* design/udd_fifo.sv */
// Short queue between front and back end of the drain delay calculator.
// Depends on udd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module udd_fifo import udd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire udd_entry_t push_data,
  input  wire logic       pop,
  output udd_entry_t      head,
  output udd_q_stat_t     stat
);

  udd_entry_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]     cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  always_comb begin
    stat.full  = (cnt_r == (QPTR_W+1)'(QDEPTH));
    stat.empty = (cnt_r == '0);
    do_push    = push && !stat.full;
    do_pop     = pop && !stat.empty;
    head       = mem_r[rd_ptr_r];

    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

/* design/udd_back.sv */
// Back end of the drain delay calculator: scales by one million, runs a
// bit-serial restoring division, rounds up, clamps and holds the result.
// Depends on udd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module udd_back import udd_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire udd_entry_t   head,
  input  wire udd_q_stat_t  q_stat,
  output logic              pop,
  input  wire logic         out_stall,
  output logic              out_valid,
  output logic [DELAY_W-1:0] out_delay_us,
  output logic [FBITS_W-1:0] out_frame_bits
);

  back_state_t         state_r, state_nxt;
  logic [NUM_W-1:0]    num_r, num_nxt;
  logic [NUM_W-1:0]    quo_r, quo_nxt;
  logic [BAUD_W-1:0]   rem_r, rem_nxt;
  logic [BAUD_W-1:0]   baud_r, baud_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [FBITS_W-1:0]  fbits_r, fbits_nxt;
  logic                zero_r, zero_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [DELAY_W-1:0]  out_delay_r, out_delay_nxt;
  logic [FBITS_W-1:0]  out_fbits_r, out_fbits_nxt;

  logic [BAUD_W:0]     rem_sh;
  logic                ge;
  logic [NUM_W:0]      ceil_q;
  logic [DELAY_W-1:0]  delay;

  always_comb begin
    state_nxt     = state_r;
    num_nxt       = num_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    baud_nxt      = baud_r;
    step_nxt      = step_r;
    fbits_nxt     = fbits_r;
    zero_nxt      = zero_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_delay_nxt = out_delay_r;
    out_fbits_nxt = out_fbits_r;
    pop           = 1'b0;

    rem_sh = {rem_r, num_r[NUM_W-1]};
    ge     = (rem_sh >= {1'b0, baud_r});
    ceil_q = {1'b0, quo_r} + (NUM_W+1)'(rem_r != '0);
    if (zero_r) begin
      delay = '0;
    end else if (ceil_q > (NUM_W+1)'(MAX_DELAY_US)) begin
      delay = MAX_DELAY_US;
    end else if (ceil_q < (NUM_W+1)'(MIN_DELAY_US)) begin
      delay = MIN_DELAY_US;
    end else begin
      delay = ceil_q[DELAY_W-1:0];
    end

    unique case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          pop       = 1'b1;
          num_nxt   = NUM_W'(NUM_W'(head.cnt_fb) * NUM_W'(USEC_PER_SEC));
          quo_nxt   = '0;
          rem_nxt   = '0;
          step_nxt  = '0;
          baud_nxt  = head.baud;
          fbits_nxt = head.fbits;
          zero_nxt  = head.zero;
          state_nxt = head.zero ? BK_FIN : BK_DIV;
        end
      end
      BK_DIV: begin
        rem_nxt  = ge ? BAUD_W'(rem_sh - {1'b0, baud_r}) : rem_sh[BAUD_W-1:0];
        quo_nxt  = {quo_r[NUM_W-2:0], ge};
        num_nxt  = {num_r[NUM_W-2:0], 1'b0};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(NUM_W-1)) begin
          state_nxt = BK_FIN;
        end
      end
      BK_FIN: begin
        // hold here until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_delay_nxt = delay;
          out_fbits_nxt = fbits_r;
          state_nxt     = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r       <= num_nxt;
    quo_r       <= quo_nxt;
    rem_r       <= rem_nxt;
    baud_r      <= baud_nxt;
    step_r      <= step_nxt;
    fbits_r     <= fbits_nxt;
    zero_r      <= zero_nxt;
    out_delay_r <= out_delay_nxt;
    out_fbits_r <= out_fbits_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_delay_us   = out_delay_r;
  assign out_frame_bits = out_fbits_r;

endmodule

`default_nettype wire

/* design/uart_drain_delay_calc_unit.sv */
// UART drain delay calculator, top level: configuration registers, front end,
// queue and back end. Depends on udd_pkg, udd_front, udd_fifo, udd_back.
// Usage:
//   Input channel (in_valid / in_stall / in_byte_count) takes the byte count
//   of a chunk; one transaction in gives exactly one transaction out on the
//   result channel (out_valid / out_stall / out_delay_us, out_frame_bits).
//   delay_us = ceil(count * frame_bits * 1e6 / baud), clamped to 1000..100000,
//   zero for an empty chunk; counts above 256 saturate to 256.
//   Configuration: cfg_valid / cfg_ready / cfg_index / cfg_wdata. cfg_ready is
//   always high; write only while no transaction is in flight.
//   Result flow for a nonzero count: queue pop and scale, 32 division steps,
//   round and clamp; a zero count skips the division. The back end takes
//   one transaction at a time; its bit-serial divider retires one quotient
//   bit per cycle, and empty chunks skip it.
//   The two-entry queue lets the input keep accepting while the divider runs
//   or a result waits in the output register.
//   Reset (rst_n low, synchronous): queue and pipeline emptied, registers
//   return to 115200 baud, 8 data bits, no parity, one stop bit.
//   When the receiver stalls, the result holds in the output register, the
//   back end holds its next result, then the queue fills and in_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module uart_drain_delay_calc_unit import udd_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [COUNT_W-1:0]   in_byte_count,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [DELAY_W-1:0]        out_delay_us,
  output logic [FBITS_W-1:0]        out_frame_bits,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BAUD_W-1:0]    cfg_wdata
);

  // Configuration registers
  logic [BAUD_W-1:0] line_rate_r, line_rate_nxt;
  logic [1:0]        data_bits_r, data_bits_nxt;
  logic              parity_r, parity_nxt;
  logic              two_stop_r, two_stop_nxt;

  udd_entry_t  entry, head;
  udd_q_stat_t q_stat;
  logic        push, pop;

  assign cfg_ready = 1'b1;

  // Decode the write; each register keeps only its own low bits.
  always_comb begin
    line_rate_nxt = line_rate_r;
    data_bits_nxt = data_bits_r;
    parity_nxt    = parity_r;
    two_stop_nxt  = two_stop_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LINE_RATE: line_rate_nxt = cfg_wdata;
        CFG_DATA_BITS: data_bits_nxt = cfg_wdata[1:0];
        CFG_PARITY_EN: parity_nxt    = cfg_wdata[0];
        CFG_TWO_STOP:  two_stop_nxt  = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_rate_r <= DEFAULT_BAUD;
      data_bits_r <= 2'd3;
      parity_r    <= 1'b0;
      two_stop_r  <= 1'b0;
    end else begin
      line_rate_r <= line_rate_nxt;
      data_bits_r <= data_bits_nxt;
      parity_r    <= parity_nxt;
      two_stop_r  <= two_stop_nxt;
    end
  end

  // Front: saturate, size the frame, snapshot the line rate
  udd_front u_front (
    .in_valid       (in_valid),
    .in_byte_count  (in_byte_count),
    .line_rate      (line_rate_r),
    .data_bits_code (data_bits_r),
    .parity_enable  (parity_r),
    .two_stop_bits  (two_stop_r),
    .q_stat         (q_stat),
    .in_stall       (in_stall),
    .push           (push),
    .entry          (entry)
  );

  // Queue: decouple acceptance from the divider
  udd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (entry),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  // Back: scale, divide, round up, clamp, hold for the receiver
  udd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .q_stat         (q_stat),
    .pop            (pop),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_delay_us   (out_delay_us),
    .out_frame_bits (out_frame_bits)
  );

  // Checks
  a_delay_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_delay_us != '0 |->
      out_delay_us >= MIN_DELAY_US && out_delay_us <= MAX_DELAY_US)
    else $error("delay outside clamp range");

  a_fbits_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_frame_bits >= FBITS_W'(7) && out_frame_bits <= FBITS_W'(12))
    else $error("frame bits outside 7..12");

  a_queue_stat: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue both full and empty");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

endmodule

`default_nettype wire
